>>> rtl/core/sprg_pkg.sv
`default_nettype none

package sprg_pkg;

   // Opcodes of an input item.
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ROTATE = 2'd1;
   localparam logic [1:0] OP_SMOOTH = 2'd2;
   localparam logic [1:0] OP_RELEASE = 2'd3;

   // Motion phases.
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_ROTATE = 2'd1;
   localparam logic [1:0] PH_RAMP   = 2'd2;
   localparam logic [1:0] PH_SETTLE = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PERIOD_TICKS   = 3'd0;
   localparam logic [2:0] CSR_MIN_PULSE      = 3'd1;
   localparam logic [2:0] CSR_MAX_PULSE      = 3'd2;
   localparam logic [2:0] CSR_ROTATE_HOLD    = 3'd3;
   localparam logic [2:0] CSR_RAMP_STEP_HOLD = 3'd4;
   localparam logic [2:0] CSR_SETTLE_HOLD    = 3'd5;

   // Register values after reset.
   localparam logic [15:0] RST_PERIOD_TICKS   = 16'd20000;
   localparam logic [11:0] RST_MIN_PULSE      = 12'd1000;
   localparam logic [11:0] RST_MAX_PULSE      = 12'd2000;
   localparam logic [7:0]  RST_ROTATE_HOLD    = 8'd50;
   localparam logic [7:0]  RST_RAMP_STEP_HOLD = 8'd3;
   localparam logic [7:0]  RST_SETTLE_HOLD    = 8'd25;

   localparam int ANGLE_MAX  = 180;
   localparam int RAMP_STEPS = 20;
   localparam int IDX_W      = $clog2(RAMP_STEPS + 1);

   // Constant division by reciprocal multiplication. The products divided
   // stay below 2^PROD_W, and with DIV_SHIFT = 34 the rounded-up reciprocal
   // gives the exact floor for every divisor below 2^14.
   localparam int PROD_W    = 20;
   localparam int DIV_SHIFT = 34;
   localparam int RECIP_W   = 28;
   localparam longint unsigned DIV_ONE = 64'd1 << DIV_SHIFT;
   localparam longint unsigned RECIP_ANGLE =
      (DIV_ONE + longint'(ANGLE_MAX) - 64'd1) / longint'(ANGLE_MAX);
   localparam longint unsigned RECIP_RAMP =
      (DIV_ONE + longint'(ANGLE_MAX * RAMP_STEPS) - 64'd1) /
      longint'(ANGLE_MAX * RAMP_STEPS);

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] angle;
   } req_type;

   typedef struct packed {
      logic        pwm_level;
      logic        busy_res;
      logic [11:0] pulse_now;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/servo_pwm_ramp_generator_unit.sv
// An accepted item reaches rsp_data through the operand, quotient and result registers.
// Throughput: one item per clock while rsp_stall is low; the three registers form a
// pipeline, and all motion state is updated in the last step only.
// Reset (synchronous, active high) empties the pipeline, returns the motion to idle with a
// low line, and loads the configuration registers with their default values.
`default_nettype none

module servo_pwm_ramp_generator_unit (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire sprg_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output sprg_pkg::rsp_type      rsp_data,
   input  wire                    csr_wr_en,
   input  wire  [2:0]             csr_index,
   input  wire  [15:0]            csr_wdata
);

   localparam int FULL_W = sprg_pkg::PROD_W + sprg_pkg::RECIP_W;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [15:0] period_ticks_ff;
   logic [11:0] min_pulse_ff;
   logic [11:0] max_pulse_ff;
   logic [7:0]  rotate_hold_ff;
   logic [7:0]  ramp_step_hold_ff;
   logic [7:0]  settle_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ticks_ff   <= sprg_pkg::RST_PERIOD_TICKS;
         min_pulse_ff      <= sprg_pkg::RST_MIN_PULSE;
         max_pulse_ff      <= sprg_pkg::RST_MAX_PULSE;
         rotate_hold_ff    <= sprg_pkg::RST_ROTATE_HOLD;
         ramp_step_hold_ff <= sprg_pkg::RST_RAMP_STEP_HOLD;
         settle_hold_ff    <= sprg_pkg::RST_SETTLE_HOLD;
      end else if (csr_wr_en) begin
         case (csr_index)
            sprg_pkg::CSR_PERIOD_TICKS:   period_ticks_ff   <= csr_wdata;
            sprg_pkg::CSR_MIN_PULSE:      min_pulse_ff      <= csr_wdata[11:0];
            sprg_pkg::CSR_MAX_PULSE:      max_pulse_ff      <= csr_wdata[11:0];
            sprg_pkg::CSR_ROTATE_HOLD:    rotate_hold_ff    <= csr_wdata[7:0];
            sprg_pkg::CSR_RAMP_STEP_HOLD: ramp_step_hold_ff <= csr_wdata[7:0];
            sprg_pkg::CSR_SETTLE_HOLD:    settle_hold_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control. Each stage moves on when the stage after it
   // is empty or is itself moving, so bubbles collapse and a waiting
   // result holds back the input only once every stage holds an item.
   // ------------------------------------------------------------------
   logic a_valid_ff, b_valid_ff, out_valid_ff;
   logic out_ready, b_ready, a_ready;
   logic b_fire;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign b_ready   = !b_valid_ff || out_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign b_fire    = b_valid_ff && out_ready;
   assign req_stall = !a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= req_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= b_valid_ff;
         end
      end
   end

   // ------------------------------------------------------------------
   // Operand stage: saturate the angle and form angle * |max - min|.
   // The sign of the span is kept aside so that both divisions below
   // work on magnitudes and truncate toward zero.
   // ------------------------------------------------------------------
   logic [7:0]                  angle_sat;
   logic [12:0]                 span;
   logic                        span_neg_in;
   logic [11:0]                 span_mag;
   logic [sprg_pkg::PROD_W-1:0] prod_in;

   logic [1:0]                  a_opcode_ff;
   logic                        a_neg_ff;
   logic [sprg_pkg::PROD_W-1:0] a_prod_ff;

   always_comb begin
      angle_sat   = (req_data.angle > 8'(sprg_pkg::ANGLE_MAX)) ?
                    8'(sprg_pkg::ANGLE_MAX) : req_data.angle;
      span        = {1'b0, max_pulse_ff} - {1'b0, min_pulse_ff};
      span_neg_in = span[12];
      span_mag    = span_neg_in ? 12'(-span) : span[11:0];
      prod_in     = {{(sprg_pkg::PROD_W - 8){1'b0}}, angle_sat} *
                    {{(sprg_pkg::PROD_W - 12){1'b0}}, span_mag};
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_opcode_ff <= req_data.opcode;
         a_neg_ff    <= span_neg_in;
         a_prod_ff   <= prod_in;
      end
   end

   // ------------------------------------------------------------------
   // Quotient stage: divide the product by 180 (pulse offset) and by
   // 180 * RAMP_STEPS (ramp increment) with exact reciprocal multiplies.
   // Truncating twice equals truncating once by the combined divisor.
   // ------------------------------------------------------------------
   localparam logic [sprg_pkg::RECIP_W-1:0] RECIP_ANGLE_C =
      sprg_pkg::RECIP_W'(sprg_pkg::RECIP_ANGLE);
   localparam logic [sprg_pkg::RECIP_W-1:0] RECIP_RAMP_C =
      sprg_pkg::RECIP_W'(sprg_pkg::RECIP_RAMP);

   logic [FULL_W-1:0] full_angle, full_ramp;
   logic [11:0]       q_angle_in, q_ramp_in;

   logic [1:0]  b_opcode_ff;
   logic        b_neg_ff;
   logic [11:0] b_q_angle_ff;
   logic [11:0] b_q_ramp_ff;

   always_comb begin
      full_angle = {{sprg_pkg::RECIP_W{1'b0}}, a_prod_ff} *
                   {{sprg_pkg::PROD_W{1'b0}}, RECIP_ANGLE_C};
      full_ramp  = {{sprg_pkg::RECIP_W{1'b0}}, a_prod_ff} *
                   {{sprg_pkg::PROD_W{1'b0}}, RECIP_RAMP_C};
      q_angle_in = full_angle[sprg_pkg::DIV_SHIFT +: 12];
      q_ramp_in  = full_ramp[sprg_pkg::DIV_SHIFT +: 12];
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_opcode_ff  <= a_opcode_ff;
         b_neg_ff     <= a_neg_ff;
         b_q_angle_ff <= q_angle_in;
         b_q_ramp_ff  <= q_ramp_in;
      end
   end

   // ------------------------------------------------------------------
   // Motion stage: rotate commands restart the motion at the start of a period, a release
   // stops it, and ticks advance the position in the period and, at its end, the hold
   // counter, the ramp and the phase.
   // ------------------------------------------------------------------
   logic [1:0]                   phase_ff, phase_in;
   logic [15:0]                  tick_ff, tick_in;
   logic [11:0]                  cur_pulse_ff, cur_pulse_in;
   logic [11:0]                  tgt_pulse_ff, tgt_pulse_in;
   logic signed [12:0]           inc_ff, inc_in;
   logic [sprg_pkg::IDX_W-1:0]   ramp_idx_ff, ramp_idx_in;
   logic [7:0]                   left_ff, left_in;

   logic [12:0] offset;
   logic [12:0] cmd_target;
   logic [12:0] cmd_inc;
   logic [15:0] tick_inc;
   logic [11:0] ramp_sum;
   logic        busy;
   logic [15:0] clip;
   sprg_pkg::rsp_type rsp_in, rsp_ff;

   // A hold count of zero lasts one period.
   function automatic logic [7:0] hold_of(input logic [7:0] hold);
      hold_of = (hold == 8'd0) ? 8'd1 : hold;
   endfunction

   always_comb begin
      offset     = b_neg_ff ? 13'(-{1'b0, b_q_angle_ff}) : {1'b0, b_q_angle_ff};
      cmd_target = {1'b0, min_pulse_ff} + offset;
      cmd_inc    = b_neg_ff ? 13'(-{1'b0, b_q_ramp_ff}) : {1'b0, b_q_ramp_ff};
      tick_inc   = tick_ff + 16'd1;
      ramp_sum   = cur_pulse_ff + inc_ff[11:0];

      phase_in     = phase_ff;
      tick_in      = tick_ff;
      cur_pulse_in = cur_pulse_ff;
      tgt_pulse_in = tgt_pulse_ff;
      inc_in       = inc_ff;
      ramp_idx_in  = ramp_idx_ff;
      left_in      = left_ff;

      if (b_fire) begin
         case (b_opcode_ff)
            sprg_pkg::OP_TICK: begin
               if (phase_ff != sprg_pkg::PH_IDLE) begin
                  if (tick_inc >= period_ticks_ff) begin
                     // End of a period.
                     tick_in = 16'd0;
                     if (left_ff > 8'd1) begin
                        left_in = left_ff - 8'd1;
                     end else if (phase_ff == sprg_pkg::PH_RAMP) begin
                        if (ramp_idx_ff < sprg_pkg::IDX_W'(sprg_pkg::RAMP_STEPS)) begin
                           ramp_idx_in  = ramp_idx_ff + sprg_pkg::IDX_W'(1);
                           cur_pulse_in = ramp_sum;
                           left_in      = hold_of(ramp_step_hold_ff);
                        end else begin
                           phase_in     = sprg_pkg::PH_SETTLE;
                           cur_pulse_in = tgt_pulse_ff;
                           left_in      = hold_of(settle_hold_ff);
                        end
                     end else begin
                        phase_in     = sprg_pkg::PH_IDLE;
                        cur_pulse_in = 12'd0;
                        tgt_pulse_in = 12'd0;
                        inc_in       = '0;
                        ramp_idx_in  = '0;
                        left_in      = 8'd0;
                     end
                  end else begin
                     tick_in = tick_inc;
                  end
               end
            end
            sprg_pkg::OP_ROTATE: begin
               phase_in     = sprg_pkg::PH_ROTATE;
               tick_in      = 16'd0;
               cur_pulse_in = cmd_target[11:0];
               tgt_pulse_in = cmd_target[11:0];
               inc_in       = '0;
               ramp_idx_in  = '0;
               left_in      = hold_of(rotate_hold_ff);
            end
            sprg_pkg::OP_SMOOTH: begin
               phase_in     = sprg_pkg::PH_RAMP;
               tick_in      = 16'd0;
               cur_pulse_in = min_pulse_ff;
               tgt_pulse_in = cmd_target[11:0];
               inc_in       = cmd_inc;
               ramp_idx_in  = '0;
               left_in      = hold_of(ramp_step_hold_ff);
            end
            default: begin
               // Release: line low at once, all motion state cleared.
               phase_in     = sprg_pkg::PH_IDLE;
               tick_in      = 16'd0;
               cur_pulse_in = 12'd0;
               tgt_pulse_in = 12'd0;
               inc_in       = '0;
               ramp_idx_in  = '0;
               left_in      = 8'd0;
            end
         endcase
      end

      // The result reflects the state after this item; the pulse is clipped
      // to the period.
      busy = phase_in != sprg_pkg::PH_IDLE;
      clip = ({4'd0, cur_pulse_in} < period_ticks_ff) ? {4'd0, cur_pulse_in} :
             period_ticks_ff;
      rsp_in.pwm_level = busy && (tick_in < clip);
      rsp_in.busy_res  = busy;
      rsp_in.pulse_now = busy ? clip[11:0] : 12'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sprg_pkg::PH_IDLE;
         tick_ff      <= 16'd0;
         cur_pulse_ff <= 12'd0;
         tgt_pulse_ff <= 12'd0;
         inc_ff       <= '0;
         ramp_idx_ff  <= '0;
         left_ff      <= 8'd0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         cur_pulse_ff <= cur_pulse_in;
         tgt_pulse_ff <= tgt_pulse_in;
         inc_ff       <= inc_in;
         ramp_idx_ff  <= ramp_idx_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // While idle the period position and the pulse stay cleared.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == sprg_pkg::PH_IDLE) |-> (tick_ff == 16'd0 && cur_pulse_ff == 12'd0))
      else $error("idle motion state not cleared");

   // The ramp never steps past its last pulse.
   assert property (@(posedge clock) disable iff (reset)
      ramp_idx_ff <= sprg_pkg::IDX_W'(sprg_pkg::RAMP_STEPS))
      else $error("ramp index beyond last step");

   // An idle result drives the line low and reports no pulse.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.busy_res) |-> (!rsp_data.pwm_level && rsp_data.pulse_now == 12'd0))
      else $error("idle result with pulse");

   // A running motion always has a hold count to work down.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != sprg_pkg::PH_IDLE) |-> (left_ff != 8'd0))
      else $error("motion without hold count");

   // Motion state changes only when an item reaches the motion stage.
   assert property (@(posedge clock) disable iff (reset)
      !$past(b_fire) && !$past(reset) |-> $stable(phase_ff) && $stable(tick_ff))
      else $error("motion state changed without an item");

endmodule

`default_nettype wire

>>> verif/servo_pwm_checker.sv
`timescale 1ns / 1ps

module servo_pwm_checker (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_stall,
   input  sprg_pkg::req_type req_data,
   input  wire               rsp_valid,
   input  wire               rsp_stall,
   input  sprg_pkg::rsp_type rsp_data,
   input  wire               csr_wr_en,
   input  wire [2:0]         csr_index,
   input  wire [15:0]        csr_wdata,
   output int                mismatches,
   output int                pending
);

   logic [15:0] cfg_period;
   logic [11:0] cfg_min_pulse;
   logic [11:0] cfg_max_pulse;
   logic [7:0]  cfg_rotate_hold;
   logic [7:0]  cfg_step_hold;
   logic [7:0]  cfg_settle_hold;

   logic [15:0]        tick_pos;
   logic [11:0]        pulse_cur;
   logic [11:0]        pulse_target;
   logic signed [12:0] step_delta;
   logic [4:0]         step_count;
   logic [7:0]         periods_to_go;
   logic [1:0]         phase;

   sprg_pkg::rsp_type expected_q[$];
   sprg_pkg::rsp_type want;
   int                result_count;

   initial begin
      mismatches   = 0;
      pending      = 0;
      result_count = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want_value);
      $display("mismatch at result %0d: %s is %0d, predicted %0d",
               result_count, what, got, want_value);
      mismatches++;
   endtask

   // A hold register that reads zero still holds for one period.
   function automatic logic [7:0] hold_count(input logic [7:0] reg_value);
      return (reg_value == 8'd0) ? 8'd1 : reg_value;
   endfunction

   function automatic logic [11:0] angle_pulse(input logic [7:0] angle);
      int deg;
      int span;
      deg  = (angle > 8'd180) ? sprg_pkg::ANGLE_MAX : int'(angle);
      span = int'(cfg_max_pulse) - int'(cfg_min_pulse);
      return 12'(int'(cfg_min_pulse) + (deg * span) / sprg_pkg::ANGLE_MAX);
   endfunction

   function automatic void stop_motion();
      tick_pos      = '0;
      pulse_cur     = '0;
      pulse_target  = '0;
      step_delta    = '0;
      step_count    = '0;
      periods_to_go = '0;
      phase         = sprg_pkg::PH_IDLE;
   endfunction

   function automatic void close_period();
      if (periods_to_go > 8'd1) begin
         periods_to_go--;
      end else if (phase == sprg_pkg::PH_RAMP) begin
         if (step_count < sprg_pkg::RAMP_STEPS) begin
            step_count++;
            pulse_cur     = 12'(int'(pulse_cur) + int'(step_delta));
            periods_to_go = hold_count(cfg_step_hold);
         end else begin
            phase         = sprg_pkg::PH_SETTLE;
            pulse_cur     = pulse_target;
            periods_to_go = hold_count(cfg_settle_hold);
         end
      end else begin
         stop_motion();
      end
   endfunction

   function automatic sprg_pkg::rsp_type predict_item(input sprg_pkg::req_type item);
      logic [15:0]       shown;
      sprg_pkg::rsp_type r;
      case (item.opcode)
         sprg_pkg::OP_TICK: begin
            if (phase != sprg_pkg::PH_IDLE) begin
               tick_pos = tick_pos + 16'd1;
               if (tick_pos >= cfg_period) begin
                  tick_pos = '0;
                  close_period();
               end
            end
         end
         sprg_pkg::OP_ROTATE: begin
            stop_motion();
            pulse_cur     = angle_pulse(item.angle);
            pulse_target  = pulse_cur;
            periods_to_go = hold_count(cfg_rotate_hold);
            phase         = sprg_pkg::PH_ROTATE;
         end
         sprg_pkg::OP_SMOOTH: begin
            stop_motion();
            pulse_target  = angle_pulse(item.angle);
            step_delta    = 13'((int'(pulse_target) - int'(cfg_min_pulse)) /
                                sprg_pkg::RAMP_STEPS);
            pulse_cur     = cfg_min_pulse;
            periods_to_go = hold_count(cfg_step_hold);
            phase         = sprg_pkg::PH_RAMP;
         end
         default: begin
            stop_motion();
         end
      endcase
      shown       = (pulse_cur < cfg_period) ? {4'd0, pulse_cur} : cfg_period;
      r.busy_res  = (phase != sprg_pkg::PH_IDLE);
      r.pwm_level = r.busy_res && (tick_pos < shown);
      r.pulse_now = r.busy_res ? shown[11:0] : 12'd0;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_period      = sprg_pkg::RST_PERIOD_TICKS;
         cfg_min_pulse   = sprg_pkg::RST_MIN_PULSE;
         cfg_max_pulse   = sprg_pkg::RST_MAX_PULSE;
         cfg_rotate_hold = sprg_pkg::RST_ROTATE_HOLD;
         cfg_step_hold   = sprg_pkg::RST_RAMP_STEP_HOLD;
         cfg_settle_hold = sprg_pkg::RST_SETTLE_HOLD;
         stop_motion();
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result with no prediction, raw", int'(rsp_data), 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.pwm_level !== want.pwm_level)
                  report_mismatch("pwm_level", int'(rsp_data.pwm_level), int'(want.pwm_level));
               if (rsp_data.busy_res !== want.busy_res)
                  report_mismatch("busy_res", int'(rsp_data.busy_res), int'(want.busy_res));
               if (rsp_data.pulse_now !== want.pulse_now)
                  report_mismatch("pulse_now", int'(rsp_data.pulse_now), int'(want.pulse_now));
            end
            result_count++;
         end
         if (csr_wr_en) begin
            case (csr_index)
               sprg_pkg::CSR_PERIOD_TICKS:   cfg_period      = csr_wdata;
               sprg_pkg::CSR_MIN_PULSE:      cfg_min_pulse   = csr_wdata[11:0];
               sprg_pkg::CSR_MAX_PULSE:      cfg_max_pulse   = csr_wdata[11:0];
               sprg_pkg::CSR_ROTATE_HOLD:    cfg_rotate_hold = csr_wdata[7:0];
               sprg_pkg::CSR_RAMP_STEP_HOLD: cfg_step_hold   = csr_wdata[7:0];
               sprg_pkg::CSR_SETTLE_HOLD:    cfg_settle_hold = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_q.push_back(predict_item(req_data));
         end
      end
      pending = expected_q.size();
   end

endmodule

>>> verif/servo_pwm_ramp_generator_unit_tb.sv
`timescale 1ns / 1ps

module servo_pwm_ramp_generator_unit_tb;

   // The two spare register indexes, which the block must ignore.
   localparam logic [2:0] CSR_SPARE_6 = 3'd6;
   localparam logic [2:0] CSR_SPARE_7 = 3'd7;

   // Generous bound on the whole run, far above the slowest legal run.
   localparam int CYCLE_LIMIT = 300000;

   typedef enum {SET_SMALL, SET_DEEP, SET_MEDIUM, SET_EXTREME} setting_kind_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   sprg_pkg::req_type req_data = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   sprg_pkg::rsp_type rsp_data;
   logic     csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int mismatches;
   int pending;
   int cycle_count = 0;

   // Percent chances of an idle sender cycle and of a stalled receiver cycle.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // Copy of the register values, used only to size tick runs so that
   // motions often run to their natural end.
   int unsigned reg_shadow[6];

   always #4 clock = ~clock;

   servo_pwm_ramp_generator_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   servo_pwm_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // The receiver stalls at random; the chance is set per phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Sends one item. It is entered and left at a falling edge with valid low.
   // The payload stays put while the block stalls it.
   task automatic push_item(input logic [1:0] op, input logic [7:0] angle);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_data.opcode = op;
      req_data.angle  = angle;
      req_valid       = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Holds off the sender until every predicted result has come back, then
   // lets the pipeline empty.
   task automatic wait_drained();
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One register write. Bits above the register's width carry random junk,
   // which the block has to drop.
   task automatic csr_write(input logic [2:0] index, input logic [15:0] value);
      logic [15:0] keep_mask;
      case (index)
         sprg_pkg::CSR_PERIOD_TICKS:                         keep_mask = 16'hFFFF;
         sprg_pkg::CSR_MIN_PULSE, sprg_pkg::CSR_MAX_PULSE:   keep_mask = 16'h0FFF;
         default:                                            keep_mask = 16'h00FF;
      endcase
      csr_index = index;
      csr_wdata = (16'($urandom) & ~keep_mask) | (value & keep_mask);
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (index <= sprg_pkg::CSR_SETTLE_HOLD) reg_shadow[index] = 32'(value & keep_mask);
   endtask

   function automatic int hold_or_one(input int unsigned reg_value);
      return (reg_value == 0) ? 1 : int'(reg_value);
   endfunction

   // Rough number of ticks a command keeps the block busy.
   function automatic int motion_len(input logic [1:0] op);
      int p;
      p = hold_or_one(reg_shadow[sprg_pkg::CSR_PERIOD_TICKS]);
      case (op)
         sprg_pkg::OP_ROTATE:
            return p * hold_or_one(reg_shadow[sprg_pkg::CSR_ROTATE_HOLD]);
         sprg_pkg::OP_SMOOTH:
            return p * ((sprg_pkg::RAMP_STEPS + 1) *
                        hold_or_one(reg_shadow[sprg_pkg::CSR_RAMP_STEP_HOLD])
                        + hold_or_one(reg_shadow[sprg_pkg::CSR_SETTLE_HOLD]));
         default:
            return 4;
      endcase
   endfunction

   // Angles lean toward the edges of the mapping and the saturation point.
   function automatic logic [7:0] pick_angle();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd180;
         2:       return 8'd181;
         3:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Loads a full register set of the given flavor once the block is idle.
   // Small sets make whole ramps short; deep sets keep the pulse below the
   // period so that every ramp step is visible on pulse_now.
   task automatic apply_settings(input setting_kind_type kind);
      logic [15:0] period;
      logic [11:0] lo;
      logic [11:0] hi;
      logic [7:0]  rot;
      logic [7:0]  step;
      logic [7:0]  settle;
      case (kind)
         SET_SMALL: begin
            period = 16'($urandom_range(0, 3));
            lo     = 12'($urandom_range(0, 63));
            hi     = 12'($urandom_range(0, 63));
            rot    = 8'($urandom_range(0, 3));
            step   = 8'($urandom_range(0, 2));
            settle = 8'($urandom_range(0, 3));
         end
         SET_DEEP: begin
            period = 16'($urandom_range(21, 24));
            if ($urandom_range(1) == 1) begin
               lo = 12'($urandom_range(0, 1));
               hi = 12'(period - 16'($urandom_range(1, 2)));
            end else begin
               lo = 12'(period - 16'($urandom_range(1, 2)));
               hi = 12'($urandom_range(0, 1));
            end
            rot    = 8'($urandom_range(1, 2));
            step   = 8'd1;
            settle = 8'($urandom_range(1, 3));
         end
         SET_MEDIUM: begin
            period = 16'($urandom_range(100, 400));
            lo     = 12'($urandom_range(0, 500));
            hi     = 12'($urandom_range(0, 500));
            rot    = 8'($urandom_range(1, 2));
            step   = 8'd1;
            settle = 8'($urandom_range(1, 2));
         end
         default: begin
            period = 16'hFFFF;
            lo     = 12'hFFF;
            hi     = 12'h000;
            rot    = 8'hFF;
            step   = 8'hFF;
            settle = 8'hFF;
         end
      endcase
      wait_drained();
      csr_write(sprg_pkg::CSR_PERIOD_TICKS, period);
      csr_write(sprg_pkg::CSR_MIN_PULSE, {4'd0, lo});
      csr_write(sprg_pkg::CSR_MAX_PULSE, {4'd0, hi});
      csr_write(sprg_pkg::CSR_ROTATE_HOLD, {8'd0, rot});
      csr_write(sprg_pkg::CSR_RAMP_STEP_HOLD, {8'd0, step});
      csr_write(sprg_pkg::CSR_SETTLE_HOLD, {8'd0, settle});
   endtask

   // Random traffic is built from commands each followed by a run of ticks.
   // Most runs lie around the motion's length, so many motions finish; the rest
   // are short, so that the next command cuts the motion off.
   task automatic run_phase(input int budget, input bit ramp_heavy);
      int          sent;
      int          run;
      int          len;
      int          roll;
      logic [1:0]  op;
      sent = 0;
      while (sent < budget) begin
         roll = $urandom_range(99);
         if (roll < (ramp_heavy ? 55 : 40))      op = sprg_pkg::OP_SMOOTH;
         else if (roll < (ramp_heavy ? 85 : 80)) op = sprg_pkg::OP_ROTATE;
         else                                    op = sprg_pkg::OP_RELEASE;
         push_item(op, pick_angle());
         sent++;
         len = motion_len(op);
         if ($urandom_range(99) < 70) run = $urandom_range(len / 2, len + 8);
         else                         run = $urandom_range(0, 8);
         for (int i = 0; i < run && sent < budget; i++) begin
            push_item(sprg_pkg::OP_TICK, 8'($urandom_range(0, 255)));
            sent++;
            // At most once per phase the sender waits for every result in flight.
            if (sent == budget / 2) wait_drained();
         end
      end
   endtask

   setting_kind_type phase_kind[7] = '{SET_SMALL, SET_DEEP, SET_SMALL, SET_EXTREME,
                                       SET_SMALL, SET_DEEP, SET_MEDIUM};
   int phase_items[7] = '{90, 450, 90, 40, 90, 420, 80};
   int phase_mode[7]  = '{0, 1, 2, 3, 3, 2, 0};

   initial begin
      reg_shadow[sprg_pkg::CSR_PERIOD_TICKS]   = 32'(sprg_pkg::RST_PERIOD_TICKS);
      reg_shadow[sprg_pkg::CSR_MIN_PULSE]      = 32'(sprg_pkg::RST_MIN_PULSE);
      reg_shadow[sprg_pkg::CSR_MAX_PULSE]      = 32'(sprg_pkg::RST_MAX_PULSE);
      reg_shadow[sprg_pkg::CSR_ROTATE_HOLD]    = 32'(sprg_pkg::RST_ROTATE_HOLD);
      reg_shadow[sprg_pkg::CSR_RAMP_STEP_HOLD] = 32'(sprg_pkg::RST_RAMP_STEP_HOLD);
      reg_shadow[sprg_pkg::CSR_SETTLE_HOLD]    = 32'(sprg_pkg::RST_SETTLE_HOLD);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed items on the reset settings: a tick while idle, rotates to
      // both ends of the range and past the saturation point, smooth rotates,
      // a release with a junk angle, and commands cutting each other off.
      push_item(sprg_pkg::OP_TICK, 8'hFF);
      push_item(sprg_pkg::OP_ROTATE, 8'd0);
      push_item(sprg_pkg::OP_TICK, 8'd0);
      push_item(sprg_pkg::OP_TICK, 8'd0);
      push_item(sprg_pkg::OP_ROTATE, 8'd180);
      push_item(sprg_pkg::OP_ROTATE, 8'd255);
      push_item(sprg_pkg::OP_TICK, 8'h00);
      push_item(sprg_pkg::OP_SMOOTH, 8'd255);
      push_item(sprg_pkg::OP_TICK, 8'h55);
      push_item(sprg_pkg::OP_RELEASE, 8'hA5);
      push_item(sprg_pkg::OP_TICK, 8'h00);
      push_item(sprg_pkg::OP_SMOOTH, 8'd90);
      push_item(sprg_pkg::OP_ROTATE, 8'd181);
      push_item(sprg_pkg::OP_RELEASE, 8'd0);

      // Corner settings: a zero period, zero hold counts, max_pulse below
      // min_pulse so the ramp runs downward, and writes to the two spare
      // indexes, which must change nothing.
      wait_drained();
      csr_write(sprg_pkg::CSR_PERIOD_TICKS, 16'd0);
      csr_write(sprg_pkg::CSR_MIN_PULSE, 16'd4095);
      csr_write(sprg_pkg::CSR_MAX_PULSE, 16'd0);
      csr_write(sprg_pkg::CSR_ROTATE_HOLD, 16'd0);
      csr_write(sprg_pkg::CSR_RAMP_STEP_HOLD, 16'd0);
      csr_write(sprg_pkg::CSR_SETTLE_HOLD, 16'd0);
      csr_write(CSR_SPARE_6, 16'hFFFF);
      csr_write(CSR_SPARE_7, 16'h5555);
      push_item(sprg_pkg::OP_SMOOTH, 8'd180);
      push_item(sprg_pkg::OP_TICK, 8'd0);
      push_item(sprg_pkg::OP_TICK, 8'd0);
      push_item(sprg_pkg::OP_TICK, 8'd0);
      push_item(sprg_pkg::OP_TICK, 8'd0);
      push_item(sprg_pkg::OP_ROTATE, 8'd90);
      push_item(sprg_pkg::OP_TICK, 8'd0);
      push_item(sprg_pkg::OP_TICK, 8'd0);

      // Random phases. Each one loads new settings while the block is idle
      // in the pipeline sense; a motion left running picks up the new
      // registers, which covers writes during a motion.
      for (int ph = 0; ph < 7; ph++) begin
         apply_settings(phase_kind[ph]);
         case (phase_mode[ph])
            1: begin
               send_idle_pct = 71;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 71;
            end
            3: begin
               send_idle_pct = 30;
               rsp_stall_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         run_phase(phase_items[ph], phase_kind[ph] == SET_DEEP);
      end

      // Let every result come back, then wait for strays.
      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
